// File: rtl/lef_pkg.sv
// Shared types, constants and arithmetic for the Laplacian edge filter.
package lef_pkg;

  localparam int MaxLine   = 1024;
  localparam int MaxRows   = 4096;
  localparam int ColW      = 10;
  localparam int RowW      = 12;
  localparam int WidthW    = 11;
  localparam int HeightW   = 13;
  localparam int PixW      = 24;
  localparam int LineW     = 2 * PixW;
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd512;
  localparam logic [HeightW-1:0] HeightReset = 13'd288;
  localparam logic [WidthW-1:0]  WidthMin    = 11'd3;
  localparam logic [WidthW-1:0]  WidthMax    = 11'd1024;
  localparam logic [HeightW-1:0] HeightMin   = 13'd3;
  localparam logic [HeightW-1:0] HeightMax   = 13'd4096;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Eight times the centre minus the neighbor sum, clamped to 0..255.
  function automatic logic [7:0] lap_clamp(input logic [7:0] ctr, input logic [10:0] nsum);
    logic signed [12:0] diff;
    diff = $signed({2'b00, ctr, 3'b000}) - $signed({2'b00, nsum});
    if (diff < 0) begin
      return 8'd0;
    end else if (diff > 13'sd255) begin
      return 8'd255;
    end
    return diff[7:0];
  endfunction

  function automatic logic [10:0] nb_sum(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [7:0] d,
                                         input logic [7:0] e, input logic [7:0] f,
                                         input logic [7:0] g, input logic [7:0] h);
    return ({3'b000, a} + {3'b000, b}) + ({3'b000, c} + {3'b000, d}) +
           ({3'b000, e} + {3'b000, f}) + ({3'b000, g} + {3'b000, h});
  endfunction

  // Columns l (x-2), c (x-1), r (x); index 0 upper, 1 middle, 2 lower row.
  function automatic pixel_t lap_pixel(input pixel_t l0, input pixel_t l1, input pixel_t l2,
                                       input pixel_t c0, input pixel_t c1, input pixel_t c2,
                                       input pixel_t r0, input pixel_t r1, input pixel_t r2);
    pixel_t res;
    res.red   = lap_clamp(c1.red, nb_sum(l0.red, l1.red, l2.red, r0.red,
                                         r1.red, r2.red, c0.red, c2.red));
    res.green = lap_clamp(c1.green, nb_sum(l0.green, l1.green, l2.green, r0.green,
                                           r1.green, r2.green, c0.green, c2.green));
    res.blue  = lap_clamp(c1.blue, nb_sum(l0.blue, l1.blue, l2.blue, r0.blue,
                                          r1.blue, r2.blue, c0.blue, c2.blue));
    return res;
  endfunction

endpackage

// File: rtl/lef_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lef_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/laplacian_edge_filter_rgb_core.sv
// Top level of the 3x3 Laplacian edge filter for RGB pixel streams.
//
// Pixels enter in raster order on the pixel channel (pixel_valid/pixel_ready)
// with frame_start marking column 0, row 0 of a new frame. For every interior
// pixel (c,r) one request leaves on the result channel (result_valid/
// result_ready) once pixel (c+1,r+1) has been taken; border pixels produce
// nothing and the sink fills them with zero. frame_last flags the last
// interior pixel of the frame.
// The block takes one pixel per clock unless the receiver stalls. A pixel
// waits in the read stage, where the two line buffers (one 48-bit wide RAM
// holding the upper and middle rows) are read at its column, and its result
// is loaded into the output register as the pixel leaves that stage, so
// result_valid rises once the pixel that completes the window has left the
// read stage. The RAM write-back for a column happens as its pixel leaves
// the read stage; a new pixel reading the same column in that cycle gets the
// written data by forwarding.
// When the receiver stalls, the output register holds its request and the
// read stage holds one more pixel; pixel_ready drops only when both are full.
// Reset (rst, synchronous) clears the pipeline, the window and the position
// counters and restores frame_width 512 and frame_height 288; the line buffers
// are not cleared, which is harmless because no result reads an unwritten
// entry. The APB port (frame_width at 0x0, frame_height at 0x4) is to be
// written only while the block is idle; the block does not enforce this.
module laplacian_edge_filter_rgb_core (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lef_pkg::PaddrW-1:0]   paddr,
  input  logic [lef_pkg::PdataW-1:0]   pwdata,
  output logic [lef_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  // Pixel channel
  input  logic                         pixel_valid,
  output logic                         pixel_ready,
  input  logic [7:0]                   red_in,
  input  logic [7:0]                   green_in,
  input  logic [7:0]                   blue_in,
  input  logic                         frame_start,
  // Result channel
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [7:0]                   red_out,
  output logic [7:0]                   green_out,
  output logic [7:0]                   blue_out,
  output logic [lef_pkg::ColW-1:0]     out_col,
  output logic [lef_pkg::RowW-1:0]     out_row,
  output logic                         frame_last
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [lef_pkg::WidthW-1:0]  frame_width;
  logic [lef_pkg::HeightW-1:0] frame_height;
  logic                        cfg_wr;
  lef_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = lef_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lef_pkg::WidthReset;
      frame_height <= lef_pkg::HeightReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lef_pkg::REG_WIDTH:  frame_width  <= pwdata[lef_pkg::WidthW-1:0];
        lef_pkg::REG_HEIGHT: frame_height <= pwdata[lef_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lef_pkg::REG_WIDTH:  prdata = {{(lef_pkg::PdataW-lef_pkg::WidthW){1'b0}}, frame_width};
      lef_pkg::REG_HEIGHT: prdata = {{(lef_pkg::PdataW-lef_pkg::HeightW){1'b0}}, frame_height};
      default:             prdata = '0;
    endcase
  end

  // Sizes outside the supported range are treated as clamped to it.
  logic [lef_pkg::WidthW-1:0]  eff_w;
  logic [lef_pkg::HeightW-1:0] eff_h;

  always_comb begin
    if (frame_width < lef_pkg::WidthMin) begin
      eff_w = lef_pkg::WidthMin;
    end else if (frame_width > lef_pkg::WidthMax) begin
      eff_w = lef_pkg::WidthMax;
    end else begin
      eff_w = frame_width;
    end
    if (frame_height < lef_pkg::HeightMin) begin
      eff_h = lef_pkg::HeightMin;
    end else if (frame_height > lef_pkg::HeightMax) begin
      eff_h = lef_pkg::HeightMax;
    end else begin
      eff_h = frame_height;
    end
  end

  // ---------------------------------------------------------------------
  // Position of the incoming pixel
  // ---------------------------------------------------------------------
  logic [lef_pkg::ColW-1:0]    col_count, col_count_next;
  logic [lef_pkg::RowW-1:0]    row_count, row_count_next;
  logic [lef_pkg::ColW-1:0]    pos_x;
  logic [lef_pkg::RowW-1:0]    pos_y;
  logic [lef_pkg::HeightW-1:0] row_wrap;
  logic [lef_pkg::WidthW-1:0]  col_plus;
  logic [lef_pkg::HeightW-1:0] row_plus;
  logic                        pix_acc;

  assign pix_acc = pixel_valid && pixel_ready;

  always_comb begin
    // A position left beyond a shrunk size wraps to the next row or frame.
    if (frame_start) begin
      pos_x    = '0;
      row_wrap = '0;
    end else if ({1'b0, col_count} >= eff_w) begin
      pos_x    = '0;
      row_wrap = {1'b0, row_count} + 1'b1;
    end else begin
      pos_x    = col_count;
      row_wrap = {1'b0, row_count};
    end
    pos_y = (row_wrap >= eff_h) ? '0 : row_wrap[lef_pkg::RowW-1:0];

    col_plus = {1'b0, pos_x} + 1'b1;
    row_plus = {1'b0, pos_y} + 1'b1;
    if (col_plus >= eff_w) begin
      col_count_next = '0;
      row_count_next = (row_plus >= eff_h) ? '0 : row_plus[lef_pkg::RowW-1:0];
    end else begin
      col_count_next = col_plus[lef_pkg::ColW-1:0];
      row_count_next = pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (pix_acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------------------------------------------------------------
  // Read stage
  // ---------------------------------------------------------------------
  logic                        s1_valid;
  logic                        s1_adv;
  logic [lef_pkg::ColW-1:0]    s1_x;
  logic [lef_pkg::RowW-1:0]    s1_y;
  lef_pkg::pixel_t             s1_px;
  logic                        s1_emit;
  logic                        s1_last;
  logic                        s1_fwd;
  logic [lef_pkg::LineW-1:0]   s1_fwd_data;
  logic [lef_pkg::LineW-1:0]   ram_rd;
  logic [lef_pkg::LineW-1:0]   lines;
  logic [lef_pkg::LineW-1:0]   line_wr;
  lef_pkg::pixel_t             up_px;
  lef_pkg::pixel_t             mid_px;
  lef_pkg::pixel_t             in_px;

  assign in_px.red   = red_in;
  assign in_px.green = green_in;
  assign in_px.blue  = blue_in;

  // The stage moves on when the output register is free or being emptied.
  assign s1_adv      = s1_valid && (!result_valid || result_ready);
  assign pixel_ready = !s1_valid || s1_adv;

  assign lines   = s1_fwd ? s1_fwd_data : ram_rd;
  assign up_px   = lines[lef_pkg::LineW-1:lef_pkg::PixW];
  assign mid_px  = lines[lef_pkg::PixW-1:0];
  // The middle row moves up and the new pixel becomes the middle row.
  assign line_wr = {mid_px, s1_px};

  lef_ram #(
    .Width (lef_pkg::LineW),
    .Depth (lef_pkg::MaxLine)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_x),
    .wr_data (line_wr),
    .rd_en   (pix_acc),
    .rd_addr (pos_x),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_x        <= pos_x;
      s1_y        <= pos_y;
      s1_px       <= in_px;
      s1_emit     <= (pos_x >= 2) && (pos_y >= 2);
      s1_last     <= ({1'b0, pos_x} == eff_w - 1'b1) && ({1'b0, pos_y} == eff_h - 1'b1);
      // The RAM returns old data when the same column is written this edge.
      s1_fwd      <= s1_adv && (s1_x == pos_x);
      s1_fwd_data <= line_wr;
    end
  end

  // ---------------------------------------------------------------------
  // Window: entries 0..2 hold column x-1, entries 3..5 column x-2
  // ---------------------------------------------------------------------
  lef_pkg::pixel_t win [6];
  lef_pkg::pixel_t edge_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= up_px;
      win[1] <= mid_px;
      win[2] <= s1_px;
    end
  end

  assign edge_px = lef_pkg::lap_pixel(win[3], win[4], win[5],
                                      win[0], win[1], win[2],
                                      up_px, mid_px, s1_px);

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      red_out    <= edge_px.red;
      green_out  <= edge_px.green;
      blue_out   <= edge_px.blue;
      out_col    <= s1_x - 1'b1;
      out_row    <= s1_y - 1'b1;
      frame_last <= s1_last;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_acc_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pix_acc |=> s1_valid)
    else $error("accepted pixel did not reach the read stage");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_x) && $stable(s1_px)))
    else $error("stalled read stage lost its pixel");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((out_col != 0) && (out_row != 0)))
    else $error("border pixel emitted");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && s1_adv && (s1_x == pos_x)) |=> s1_fwd)
    else $error("missing forward on same-column access");

endmodule
